>>> rtl/core/sdtds_pkg.sv
// Package for the single-digit time display sequencer: beat types, constants, digit split.
package sdtds_pkg;

   // Width of the millisecond counter; it saturates at all ones
   localparam int COUNTER_BITS = 16;

   // Configuration register indexes
   localparam logic [1:0] CSR_INTRO_FRAME = 2'd0;
   localparam logic [1:0] CSR_DIGIT_SLOT  = 2'd1;
   localparam logic [1:0] CSR_PAUSE       = 2'd2;

   // Configuration reset values
   localparam logic [15:0] INTRO_FRAME_RESET = 16'd50;
   localparam logic [15:0] DIGIT_SLOT_RESET  = 16'd300;
   localparam logic [15:0] PAUSE_RESET       = 16'd2000;

   // Intro countdown start and last slot index of one pass
   localparam logic [3:0] INTRO_TOP      = 4'd9;
   localparam logic [3:0] SHOW_LAST_SLOT = 4'd7;

   // Command codes
   localparam logic CMD_STEP  = 1'b0;
   localparam logic CMD_START = 1'b1;

   typedef struct packed {
      logic       command;
      logic       ms_elapsed;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [7:0] repeat_count;
   } req_payload_type;

   typedef struct packed {
      logic       digit_lit;
      logic [3:0] digit_value;
      logic       led_locked;
      logic       led_clamp_request;
      logic       led_restore_request;
      logic       busy_res;
   } rsp_payload_type;

   // Split a 6-bit value into tens and units by comparing against multiples of ten
   function automatic logic [7:0] split_tens(input logic [5:0] value);
      logic [3:0] tens;
      logic [5:0] rest;
      begin
         if (value >= 6'd60) begin
            tens = 4'd6;
            rest = value - 6'd60;
         end else if (value >= 6'd50) begin
            tens = 4'd5;
            rest = value - 6'd50;
         end else if (value >= 6'd40) begin
            tens = 4'd4;
            rest = value - 6'd40;
         end else if (value >= 6'd30) begin
            tens = 4'd3;
            rest = value - 6'd30;
         end else if (value >= 6'd20) begin
            tens = 4'd2;
            rest = value - 6'd20;
         end else if (value >= 6'd10) begin
            tens = 4'd1;
            rest = value - 6'd10;
         end else begin
            tens = 4'd0;
            rest = value;
         end
         split_tens = {tens, rest[3:0]};
      end
   endfunction

endpackage

>>> rtl/core/single_digit_time_display_sequencer.sv
// Top level of the single-digit time display sequencer: input register, phase logic, result register.
// A beat passes through the input register and then the result register; rsp_stall can hold it between them.
// Throughput: one beat per cycle while rsp_stall is low; the result register frees in the cycle its beat is taken.
// The phase update is a single pass of compares and a tens/units split between the two registers.
// Reset (synchronous, active high) empties both registers, returns the phase to idle,
// clears all sequencer state and reloads the configuration defaults.
module single_digit_time_display_sequencer
   import sdtds_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   // result channel
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   // configuration writes
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_data
);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_INIT    = 3'd1,
      PH_INTRO   = 3'd2,
      PH_SHOW    = 3'd3,
      PH_PAUSE   = 3'd4,
      PH_CLEANUP = 3'd5
   } phase_type;

   localparam logic [COUNTER_BITS-1:0] MS_MAX = {COUNTER_BITS{1'b1}};
   localparam int CMP_BITS = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

   // configuration
   logic [15:0] intro_frame_ff;
   logic [15:0] digit_slot_ff;
   logic [15:0] pause_ff;

   // input register
   logic            in_valid_ff;
   req_payload_type in_beat_ff;

   // result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_beat_ff;
   rsp_payload_type rsp_beat_in;

   // sequencer state
   phase_type               phase_ff, phase_in;
   logic [COUNTER_BITS-1:0] ms_ff, ms_in;
   logic [3:0]              frame_ff, frame_in;
   logic [7:0]              pass_ff, pass_in;
   logic [4:0]              hour_ff, hour_in;
   logic [5:0]              minute_ff, minute_in;
   logic [7:0]              repeat_ff, repeat_in;
   logic [3:0]              digit_ff, digit_in;
   logic                    lit_ff, lit_in;
   logic                    lock_ff, lock_in;

   logic       advance;
   logic       process;
   logic       clamp;
   logic       restore;
   logic       intro_due;
   logic       slot_due;
   logic       pause_due;
   logic       passes_done;
   logic [7:0] hour_split;
   logic [7:0] minute_split;
   logic [COUNTER_BITS-1:0] ms_counted;

   // Move the input beat on whenever the result register is empty or being taken
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign process   = in_valid_ff & advance;
   assign req_stall = in_valid_ff & ~advance;
   assign csr_ready = 1'b1;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_beat_ff;

   assign hour_split   = split_tens({1'b0, hour_ff});
   assign minute_split = split_tens(minute_ff);

   // Count the elapsed millisecond, holding at the top
   assign ms_counted = (in_beat_ff.ms_elapsed && ms_ff != MS_MAX) ?
                       ms_ff + 1'b1 : ms_ff;

   assign intro_due = CMP_BITS'(ms_counted) >= CMP_BITS'(intro_frame_ff);
   assign slot_due  = CMP_BITS'(ms_counted) >= CMP_BITS'(digit_slot_ff);
   assign pause_due = CMP_BITS'(ms_counted) >= CMP_BITS'(pause_ff);
   assign passes_done = (repeat_ff == 8'd0) ||
                        ({1'b0, pass_ff} + 9'd1 >= {1'b0, repeat_ff});

   // Next sequencer state for the beat in the input register
   always_comb begin
      phase_in  = phase_ff;
      ms_in     = ms_counted;
      frame_in  = frame_ff;
      pass_in   = pass_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      repeat_in = repeat_ff;
      digit_in  = digit_ff;
      lit_in    = lit_ff;
      lock_in   = lock_ff;
      clamp     = 1'b0;
      restore   = 1'b0;
      if (in_beat_ff.command == CMD_START) begin
         hour_in   = in_beat_ff.hour;
         minute_in = in_beat_ff.minute;
         repeat_in = in_beat_ff.repeat_count;
         frame_in  = 4'd0;
         pass_in   = 8'd0;
         phase_in  = PH_INIT;
      end else begin
         unique case (phase_ff)
            PH_INIT: begin
               clamp    = 1'b1;
               lock_in  = 1'b1;
               phase_in = PH_INTRO;
            end
            PH_INTRO: begin
               if (intro_due) begin
                  ms_in = '0;
                  if (frame_ff > INTRO_TOP) begin
                     frame_in = 4'd0;
                     digit_in = 4'd0;
                     lit_in   = 1'b0;
                     phase_in = PH_SHOW;
                  end else begin
                     digit_in = INTRO_TOP - frame_ff;
                     lit_in   = 1'b1;
                     frame_in = frame_ff + 4'd1;
                  end
               end
            end
            PH_SHOW: begin
               if (slot_due) begin
                  ms_in = '0;
                  if (frame_ff >= SHOW_LAST_SLOT) begin
                     frame_in = 4'd0;
                     digit_in = 4'd0;
                     lit_in   = 1'b0;
                     phase_in = PH_PAUSE;
                  end else begin
                     frame_in = frame_ff + 4'd1;
                     lit_in   = 1'b1;
                     case (frame_ff)
                        4'd0:    digit_in = hour_split[7:4];
                        4'd2:    digit_in = hour_split[3:0];
                        4'd4:    digit_in = minute_split[7:4];
                        4'd6:    digit_in = minute_split[3:0];
                        default: begin
                           digit_in = 4'd0;
                           lit_in   = 1'b0;
                        end
                     endcase
                  end
               end
            end
            PH_PAUSE: begin
               if (passes_done) begin
                  phase_in = PH_CLEANUP;
               end else if (pause_due) begin
                  ms_in    = '0;
                  pass_in  = pass_ff + 8'd1;
                  phase_in = PH_SHOW;
               end
            end
            PH_CLEANUP: begin
               lock_in  = 1'b0;
               restore  = 1'b1;
               frame_in = 4'd0;
               pass_in  = 8'd0;
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      rsp_beat_in.digit_lit           = lit_in;
      rsp_beat_in.digit_value         = digit_in;
      rsp_beat_in.led_locked          = lock_in;
      rsp_beat_in.led_clamp_request   = clamp;
      rsp_beat_in.led_restore_request = restore;
      rsp_beat_in.busy_res            = (phase_in != PH_IDLE);
   end

   // Hold state, configuration and the valid flags of both beat registers
   always_ff @(posedge clock) begin
      if (reset) begin
         intro_frame_ff <= INTRO_FRAME_RESET;
         digit_slot_ff  <= DIGIT_SLOT_RESET;
         pause_ff       <= PAUSE_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_IDLE;
         ms_ff          <= '0;
         frame_ff       <= 4'd0;
         pass_ff        <= 8'd0;
         hour_ff        <= 5'd0;
         minute_ff      <= 6'd0;
         repeat_ff      <= 8'd0;
         digit_ff       <= 4'd0;
         lit_ff         <= 1'b0;
         lock_ff        <= 1'b0;
      end else begin
         // configuration writes; an index beyond the list is dropped
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_INTRO_FRAME: intro_frame_ff <= csr_data;
               CSR_DIGIT_SLOT:  digit_slot_ff  <= csr_data;
               CSR_PAUSE:       pause_ff       <= csr_data;
               default: ;
            endcase
         end
         // input register
         if (~req_stall) begin
            in_valid_ff <= req_valid;
         end
         // result register and state advance
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (process) begin
            phase_ff  <= phase_in;
            ms_ff     <= ms_in;
            frame_ff  <= frame_in;
            pass_ff   <= pass_in;
            hour_ff   <= hour_in;
            minute_ff <= minute_in;
            repeat_ff <= repeat_in;
            digit_ff  <= digit_in;
            lit_ff    <= lit_in;
            lock_ff   <= lock_in;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (~req_stall && req_valid) begin
         in_beat_ff <= req_payload;
      end
      if (process) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

endmodule
